FILE: rtl/core/nll_pkg.sv
// ----------------------------------------------------------------------------
// nll_pkg
// Shared types, codes and helpers for the nonlinear ladder low-pass core.
// ----------------------------------------------------------------------------
package nll_pkg;

    // Multiplier and accumulator widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = 65;
    localparam int ACC_W   = 66;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESONANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE     = 2'd2;

    // Feedback weights, Q0.30
    localparam logic signed [31:0] W_CUR = 32'sd387503761;
    localparam logic signed [31:0] W_H1  = 32'sd448061726;
    localparam logic signed [31:0] W_H2  = 32'sd191014376;
    localparam logic signed [31:0] W_H3  = 32'sd47215112;

    // Datapath operations
    typedef logic [4:0] op_t;
    localparam op_t OP_NONE      = 5'd0;
    localparam op_t OP_LOAD      = 5'd1;
    localparam op_t OP_MUL_DRV   = 5'd2;
    localparam op_t OP_SET_X     = 5'd3;
    localparam op_t OP_SH_LOAD   = 5'd4;
    localparam op_t OP_MUL_SQ    = 5'd5;
    localparam op_t OP_DIV_INIT  = 5'd6;
    localparam op_t OP_DIV_STEP  = 5'd7;
    localparam op_t OP_MUL_R     = 5'd8;
    localparam op_t OP_SH_END    = 5'd9;
    localparam op_t OP_XS        = 5'd10;
    localparam op_t OP_MUL_W     = 5'd11;
    localparam op_t OP_ACC       = 5'd12;
    localparam op_t OP_FB        = 5'd13;
    localparam op_t OP_MUL_K     = 5'd14;
    localparam op_t OP_ARG       = 5'd15;
    localparam op_t OP_SAVE_A    = 5'd16;
    localparam op_t OP_MUL_CF    = 5'd17;
    localparam op_t OP_UPD       = 5'd18;
    localparam op_t OP_OUT       = 5'd19;

    // Operand selects for the shaper input
    typedef logic [2:0] sel_t;
    localparam sel_t SRC_X   = 3'd0;
    localparam sel_t SRC_ARG = 3'd1;
    localparam sel_t SRC_S1  = 3'd2;
    localparam sel_t SRC_S2  = 3'd3;
    localparam sel_t SRC_S3  = 3'd4;
    localparam sel_t SRC_S4  = 3'd5;

    typedef struct packed {
        op_t  op;
        sel_t sel;
        logic first;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Saturate a wide signed value to the 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
        lo = ~hi;
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

FILE: rtl/core/nll_datapath.sv
// ----------------------------------------------------------------------------
// nll_datapath
// Registers, shared multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module nll_datapath
    import nll_pkg::*;
#(
    parameter int FRAC_BITS    = 24,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  cmd_t                           cmd,
    output status_t                        status,
    output logic [SAMPLE_WIDTH-1:0]        sample_out,
    output logic                           out_valid,
    input  logic                           out_ready
);

    localparam int QUO_W = FRAC_BITS + 1;
    localparam logic [63:0] C27 = 64'd27 << FRAC_BITS;
    localparam logic signed [63:0] Y_HI = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] Y_LO = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

    logic [16:0]              cutoff_reg;
    logic [16:0]              res_reg;
    logic [15:0]              drive_reg;
    logic signed [31:0]       s_reg [4];
    logic signed [31:0]       h_reg [3];
    logic                     valid_reg;
    logic signed [31:0]       x_reg;
    logic signed [31:0]       arg_reg;
    logic signed [31:0]       fb_reg;
    logic signed [31:0]       sh_x_reg;
    logic signed [31:0]       sh_y_reg;
    logic signed [31:0]       a_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [63:0]              rem_reg;
    logic [63:0]              den_reg;
    logic [QUO_W-1:0]         nlo_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [SAMPLE_WIDTH-1:0]  out_reg;

    logic [16:0]              cf;
    logic [18:0]              kq;
    logic signed [31:0]       x_in;
    logic signed [63:0]       y_wide;
    logic [SAMPLE_WIDTH-1:0]  y_sat;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] prod_sh12;
    logic signed [PROD_W-1:0] prod_sh16;
    logic signed [PROD_W-1:0] prod_shf;
    logic signed [ACC_W-1:0]  acc_sh30;
    logic [63:0]              q_w;
    logic [63:0]              num_w;
    logic [63:0]              den_w;
    logic [64:0]              rem2;
    logic                     ge;
    logic signed [31:0]       sh_src;

    // Clamp coefficients to one
    assign cf = (cutoff_reg > 17'd65536) ? 17'd65536 : cutoff_reg;
    assign kq = {((res_reg > 17'd65536) ? 17'd65536 : res_reg), 2'b00};

    // Scale the sample to unit range and back
    generate
        if (FRAC_BITS >= SAMPLE_WIDTH - 1) begin : g_up
            assign x_in   = 32'(sample_in) <<< (FRAC_BITS - SAMPLE_WIDTH + 1);
            assign y_wide = 64'(fb_reg) >>> (FRAC_BITS - SAMPLE_WIDTH + 1);
        end
        else begin : g_dn
            assign x_in   = 32'(sample_in >>> (SAMPLE_WIDTH - 1 - FRAC_BITS));
            assign y_wide = 64'(fb_reg) <<< (SAMPLE_WIDTH - 1 - FRAC_BITS);
        end
    endgenerate

    assign y_sat = (y_wide > Y_HI) ? Y_HI[SAMPLE_WIDTH-1:0] :
                   (y_wide < Y_LO) ? Y_LO[SAMPLE_WIDTH-1:0] : y_wide[SAMPLE_WIDTH-1:0];

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_DRV:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(drive_reg);
            end
            OP_MUL_SQ:
            begin
                mul_a = MUL_A_W'(sh_x_reg);
                mul_b = sh_x_reg;
            end
            OP_MUL_R:
            begin
                mul_a = MUL_A_W'(sh_x_reg);
                mul_b = MUL_B_W'(quo_reg);
            end
            OP_MUL_W:
            begin
                case (sel_t'(cmd.sel))
                    3'd0:
                    begin
                        mul_a = MUL_A_W'(s_reg[3]);
                        mul_b = W_CUR;
                    end
                    3'd1:
                    begin
                        mul_a = MUL_A_W'(h_reg[0]);
                        mul_b = W_H1;
                    end
                    3'd2:
                    begin
                        mul_a = MUL_A_W'(h_reg[1]);
                        mul_b = W_H2;
                    end
                    default:
                    begin
                        mul_a = MUL_A_W'(h_reg[2]);
                        mul_b = W_H3;
                    end
                endcase
            end
            OP_MUL_K:
            begin
                mul_a = MUL_A_W'(fb_reg);
                mul_b = MUL_B_W'(kq);
            end
            OP_MUL_CF:
            begin
                mul_a = MUL_A_W'(a_reg) - MUL_A_W'(sh_y_reg);
                mul_b = MUL_B_W'(cf);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c    = mul_a * mul_b;
    assign prod_sh12 = prod_reg >>> 12;
    assign prod_sh16 = prod_reg >>> 16;
    assign prod_shf  = prod_reg >>> FRAC_BITS;
    assign acc_sh30  = acc_reg >>> 30;

    // Divider setup from the squared value
    assign q_w   = 64'(prod_reg[63:FRAC_BITS]);
    assign num_w = (C27 + q_w) << FRAC_BITS;
    assign den_w = C27 + (q_w << 3) + q_w;

    // One restoring division step
    assign rem2 = {rem_reg, nlo_reg[QUO_W-1]};
    assign ge   = (rem2 >= {1'b0, den_reg});

    // Shaper input select
    always_comb
    begin
        case (cmd.sel)
            SRC_X:   sh_src = x_reg;
            SRC_ARG: sh_src = arg_reg;
            SRC_S1:  sh_src = s_reg[0];
            SRC_S2:  sh_src = s_reg[1];
            SRC_S3:  sh_src = s_reg[2];
            default: sh_src = s_reg[3];
        endcase
    end

    // Configuration, ladder state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= 17'd65536;
            res_reg    <= 17'd0;
            drive_reg  <= 16'd4096;
            for (int i = 0; i < 4; i++)
            begin
                s_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                h_reg[i] <= '0;
            end
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CUTOFF:    cutoff_reg <= cfg_data;
                    CFG_RESONANCE: res_reg    <= cfg_data;
                    CFG_DRIVE:     drive_reg  <= cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (cmd.op == OP_FB)
            begin
                h_reg[2] <= h_reg[1];
                h_reg[1] <= h_reg[0];
                h_reg[0] <= s_reg[3];
            end
            if (cmd.op == OP_UPD)
            begin
                s_reg[cmd.sel[1:0]] <= sat32(ACC_W'(s_reg[cmd.sel[1:0]]) + ACC_W'(prod_sh16));
            end
            if (cmd.op == OP_OUT)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MUL_DRV, OP_MUL_SQ, OP_MUL_R, OP_MUL_W, OP_MUL_K, OP_MUL_CF:
                prod_reg <= prod_c;
            default: ;
        endcase
        case (cmd.op)
            OP_LOAD:     x_reg <= x_in;
            OP_SET_X:    x_reg <= sat32(ACC_W'(prod_sh12));
            OP_XS:       x_reg <= sh_y_reg;
            OP_SH_LOAD:  sh_x_reg <= sh_src;
            OP_SH_END:   sh_y_reg <= sat32(ACC_W'(prod_shf));
            OP_ACC:      acc_reg <= (cmd.first ? '0 : acc_reg) + ACC_W'(prod_reg);
            OP_FB:       fb_reg <= sat32(acc_sh30);
            OP_ARG:      arg_reg <= sat32(ACC_W'(x_reg) - ACC_W'(prod_sh16));
            OP_SAVE_A:   a_reg <= sh_y_reg;
            OP_OUT:      out_reg <= y_sat;
            OP_DIV_INIT:
            begin
                rem_reg <= num_w >> QUO_W;
                nlo_reg <= num_w[QUO_W-1:0];
                den_reg <= den_w;
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= ge ? 64'(rem2 - {1'b0, den_reg}) : rem2[63:0];
                nlo_reg <= {nlo_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
            end
            default: ;
        endcase
    end

    assign status.out_free = !valid_reg || out_ready;
    assign sample_out      = out_reg;
    assign out_valid       = valid_reg;

endmodule

FILE: rtl/core/nll_ctrl.sv
// ----------------------------------------------------------------------------
// nll_ctrl
// Sequencer that walks one sample through drive, shaper, feedback and stages.
// ----------------------------------------------------------------------------
module nll_ctrl
    import nll_pkg::*;
#(
    parameter int FRAC_BITS = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int BIT_W = $clog2(FRAC_BITS + 1);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_DRV_MUL = 5'd1;
    localparam logic [4:0] ST_DRV_SET = 5'd2;
    localparam logic [4:0] ST_SH_LOAD = 5'd3;
    localparam logic [4:0] ST_SH_SQ   = 5'd4;
    localparam logic [4:0] ST_SH_INIT = 5'd5;
    localparam logic [4:0] ST_SH_DIV  = 5'd6;
    localparam logic [4:0] ST_SH_MUL  = 5'd7;
    localparam logic [4:0] ST_SH_END  = 5'd8;
    localparam logic [4:0] ST_X_SET   = 5'd9;
    localparam logic [4:0] ST_W_MUL   = 5'd10;
    localparam logic [4:0] ST_W_ACC   = 5'd11;
    localparam logic [4:0] ST_FB      = 5'd12;
    localparam logic [4:0] ST_K_MUL   = 5'd13;
    localparam logic [4:0] ST_ARG     = 5'd14;
    localparam logic [4:0] ST_SAVE_A  = 5'd15;
    localparam logic [4:0] ST_CF_MUL  = 5'd16;
    localparam logic [4:0] ST_UPD     = 5'd17;
    localparam logic [4:0] ST_OUT     = 5'd18;

    localparam logic [1:0] RET_X = 2'd0;
    localparam logic [1:0] RET_A = 2'd1;
    localparam logic [1:0] RET_B = 2'd2;

    logic [4:0]       state_reg, state_next;
    logic [1:0]       ret_reg, ret_next;
    logic [1:0]       stage_reg, stage_next;
    logic [1:0]       wcnt_reg, wcnt_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_X;
            stage_reg <= '0;
            wcnt_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            stage_reg <= stage_next;
            wcnt_reg  <= wcnt_next;
            bit_reg   <= bit_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Advance through the sample schedule
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        stage_next = stage_reg;
        wcnt_next  = wcnt_reg;
        bit_next   = bit_reg;
        cmd        = '{op: OP_NONE, sel: SRC_X, first: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DRV_MUL;
                end
            end
            ST_DRV_MUL:
            begin
                cmd.op     = OP_MUL_DRV;
                state_next = ST_DRV_SET;
            end
            ST_DRV_SET:
            begin
                cmd.op     = OP_SET_X;
                ret_next   = RET_X;
                state_next = ST_SH_LOAD;
            end
            ST_SH_LOAD:
            begin
                cmd.op = OP_SH_LOAD;
                if (ret_reg == RET_X)
                    cmd.sel = SRC_X;
                else if (ret_reg == RET_A)
                    cmd.sel = SRC_ARG + sel_t'(stage_reg);
                else
                    cmd.sel = SRC_S1 + sel_t'(stage_reg);
                state_next = ST_SH_SQ;
            end
            ST_SH_SQ:
            begin
                cmd.op     = OP_MUL_SQ;
                state_next = ST_SH_INIT;
            end
            ST_SH_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                bit_next   = '0;
                state_next = ST_SH_DIV;
            end
            ST_SH_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (bit_reg == BIT_W'(FRAC_BITS))
                    state_next = ST_SH_MUL;
                else
                    bit_next = bit_reg + 1'b1;
            end
            ST_SH_MUL:
            begin
                cmd.op     = OP_MUL_R;
                state_next = ST_SH_END;
            end
            ST_SH_END:
            begin
                cmd.op = OP_SH_END;
                if (ret_reg == RET_X)
                    state_next = ST_X_SET;
                else if (ret_reg == RET_A)
                    state_next = ST_SAVE_A;
                else
                    state_next = ST_CF_MUL;
            end
            ST_X_SET:
            begin
                cmd.op     = OP_XS;
                wcnt_next  = '0;
                state_next = ST_W_MUL;
            end
            ST_W_MUL:
            begin
                cmd.op     = OP_MUL_W;
                cmd.sel    = sel_t'(wcnt_reg);
                state_next = ST_W_ACC;
            end
            ST_W_ACC:
            begin
                cmd.op    = OP_ACC;
                cmd.first = (wcnt_reg == 2'd0);
                if (wcnt_reg == 2'd3)
                    state_next = ST_FB;
                else
                begin
                    wcnt_next  = wcnt_reg + 1'b1;
                    state_next = ST_W_MUL;
                end
            end
            ST_FB:
            begin
                cmd.op     = OP_FB;
                state_next = ST_K_MUL;
            end
            ST_K_MUL:
            begin
                cmd.op     = OP_MUL_K;
                state_next = ST_ARG;
            end
            ST_ARG:
            begin
                cmd.op     = OP_ARG;
                stage_next = '0;
                ret_next   = RET_A;
                state_next = ST_SH_LOAD;
            end
            ST_SAVE_A:
            begin
                cmd.op     = OP_SAVE_A;
                ret_next   = RET_B;
                state_next = ST_SH_LOAD;
            end
            ST_CF_MUL:
            begin
                cmd.op     = OP_MUL_CF;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.op  = OP_UPD;
                cmd.sel = sel_t'(stage_reg);
                if (stage_reg == 2'd3)
                    state_next = ST_OUT;
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    ret_next   = RET_A;
                    state_next = ST_SH_LOAD;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/nonlinear_ladder_lowpass.sv
// ----------------------------------------------------------------------------
// nonlinear_ladder_lowpass
// Four-pole nonlinear ladder low-pass with drive, soft clipping and resonance.
// Each sample takes nine shaper passes, each running a FRAC_BITS+1 step divider.
// One sample is in work at a time; the next transfer is taken once the result
// is in the output register, which may still wait for m_tready.
// Reset: asynchronous, clears stages, history and output valid, sets config registers to defaults.
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass
    import nll_pkg::*;
#(
    parameter int FRAC_BITS    = 24,
    parameter int SAMPLE_WIDTH = 16,
    localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // sample_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // sample_out
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t                    cmd;
    status_t                 status;
    logic [SAMPLE_WIDTH-1:0] sample_out;

    // Sequencer
    nll_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and state
    nll_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .cmd        (cmd),
        .status     (status),
        .sample_out (sample_out),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = TDATA_W'(sample_out);

endmodule

FILE: rtl/core/nll_checker.sv
// ----------------------------------------------------------------------------
// nll_checker
// Port-level checks on the ladder low-pass stream behavior.
// ----------------------------------------------------------------------------
module nll_checker
#(
    parameter int SAMPLE_WIDTH = 16,
    localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TDATA_W-1:0]    m_tdata    // sample_out
);

    // A transfer starts work, so the input side closes
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after transfer");

    // A new result appears only at the end of a busy period
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

    // A stalled result holds
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind nonlinear_ladder_lowpass nll_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_nll_checker (.*);
